// ----- hw/rtl/clwa_pkg.sv -----
// Shared constants and types for the convex lens warp address generator.
// No dependencies; the divider cell and the top level use it by scoped names.
package clwa_pkg;

  // Width of the radius register and of the distance that is compared against it
  localparam int RAD_W = 13;

  // Width of the source coordinate fields on the result stream
  localparam int SRC_W = 14;

  // Width of the configuration register index
  localparam int CFG_IDX_W = 2;

  // Configuration register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X = 2'd0,
    REG_CENTER_Y = 2'd1,
    REG_RADIUS   = 2'd2
  } cfg_reg_e;

endpackage

// ----- hw/rtl/convex_lens_warp_address.sv -----
// Convex lens warp address generator, top level.
// Depends on clwa_pkg, clwa_sqrt_cell and clwa_div_cell.
//
// Takes one pixel coordinate per cycle while the result stream is ready and
// returns one source coordinate per pixel, in order. Three front stages form
// the offsets, their squares and the squared distance; a chain of
// COORD_BITS+1 square root cells settles one root bit each; one stage compares
// against the radius and scales the offsets by the distance; a chain of
// COORD_BITS divider cells settles one quotient bit each; the output register
// holds the result. A stage moves on whenever the next one can take its
// content, and backpressure on the result stream stalls the chain cell by
// cell, while empty cells keep taking input.
// Write the configuration registers only while no transaction is in flight.
module convex_lens_warp_address #(
  parameter int COORD_BITS = 12
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write port
  input  logic                              cfg_we_i,
  input  logic [clwa_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [((COORD_BITS > clwa_pkg::RAD_W) ? COORD_BITS : clwa_pkg::RAD_W)-1:0]
                                            cfg_data_i,
  // Pixel stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata: pixel_x, pixel_y (from bit 0 up), zero padded
  input  logic [((2*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
  // Source coordinate stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // tdata: source_x, source_y (from bit 0 up), zero padded
  output logic [((2*clwa_pkg::SRC_W+7)/8)*8-1:0] m_axis_tdata,
  // tuser: inside_lens
  output logic                              m_axis_tuser
);

  localparam int C       = COORD_BITS;
  localparam int RAD_W   = clwa_pkg::RAD_W;
  localparam int SRC_W   = clwa_pkg::SRC_W;
  localparam int OUT_W   = ((2*SRC_W+7)/8)*8;
  localparam int SQP_W   = 2*C;
  localparam int SQ_W    = 2*C + 1;
  localparam int RT_W    = C + 1;
  localparam int MW      = (RT_W > RAD_W) ? RT_W : RAD_W;
  localparam int NUM_W   = C + RAD_W;
  localparam int Q_W     = C;
  localparam int EXT_W   = (C + 2 > SRC_W) ? C + 2 : SRC_W;
  localparam int PASS1_W = 4*C + 2;
  localparam int PASS2_W = 2*C + 3;

  // ---------------------------------------------------------------- config
  logic [C-1:0]     cx_q, cy_q;
  logic [RAD_W-1:0] radius_q;

  // Latch register writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q     <= '0;
      cy_q     <= '0;
      radius_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        clwa_pkg::REG_CENTER_X: cx_q     <= cfg_data_i[C-1:0];
        clwa_pkg::REG_CENTER_Y: cy_q     <= cfg_data_i[C-1:0];
        clwa_pkg::REG_RADIUS:   radius_q <= cfg_data_i[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- stage A
  logic [C-1:0] px_in, py_in;
  logic [C:0]   dx_s, dy_s;
  logic         a_valid_q, a_ready, b_ready;
  logic [C-1:0] a_px_q, a_py_q, a_magx_q, a_magy_q;
  logic         a_sgnx_q, a_sgny_q;

  assign px_in = s_axis_tdata[C-1:0];
  assign py_in = s_axis_tdata[2*C-1:C];

  // Offsets from the center in sign and magnitude
  always_comb begin
    dx_s = {1'b0, px_in} - {1'b0, cx_q};
    dy_s = {1'b0, py_in} - {1'b0, cy_q};
  end

  assign a_ready       = !a_valid_q || b_ready;
  assign s_axis_tready = a_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (a_ready) begin
      a_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && s_axis_tvalid) begin
      a_px_q   <= px_in;
      a_py_q   <= py_in;
      a_sgnx_q <= dx_s[C];
      a_sgny_q <= dy_s[C];
      a_magx_q <= dx_s[C] ? C'(-dx_s) : dx_s[C-1:0];
      a_magy_q <= dy_s[C] ? C'(-dy_s) : dy_s[C-1:0];
    end
  end

  // ---------------------------------------------------------------- stage B
  logic                b_valid_q, c_ready;
  logic [SQP_W-1:0]    b_sqx_q, b_sqy_q;
  logic [PASS1_W-1:0]  b_pass_q;

  assign b_ready = !b_valid_q || c_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_ready) begin
      b_valid_q <= a_valid_q;
    end
  end

  // Square each offset
  always_ff @(posedge clk_i) begin
    if (b_ready && a_valid_q) begin
      b_sqx_q  <= SQP_W'(a_magx_q) * SQP_W'(a_magx_q);
      b_sqy_q  <= SQP_W'(a_magy_q) * SQP_W'(a_magy_q);
      b_pass_q <= {a_magy_q, a_magx_q, a_sgny_q, a_sgnx_q, a_py_q, a_px_q};
    end
  end

  // ---------------------------------------------------------------- stage C
  logic               c_valid_q;
  logic [SQ_W-1:0]    c_sum_q;
  logic [PASS1_W-1:0] c_pass_q;
  logic               sq_ready [0:RT_W];

  assign c_ready = !c_valid_q || sq_ready[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (c_ready) begin
      c_valid_q <= b_valid_q;
    end
  end

  // Squared distance
  always_ff @(posedge clk_i) begin
    if (c_ready && b_valid_q) begin
      c_sum_q  <= SQ_W'(b_sqx_q) + SQ_W'(b_sqy_q);
      c_pass_q <= b_pass_q;
    end
  end

  // ---------------------------------------------------------- root chain
  logic               sq_valid [0:RT_W];
  logic [SQ_W-1:0]    sq_rem   [0:RT_W];
  logic [RT_W-1:0]    sq_root  [0:RT_W];
  logic [PASS1_W-1:0] sq_pass  [0:RT_W];
  logic               m_ready;

  assign sq_valid[0] = c_valid_q;
  assign sq_rem[0]   = c_sum_q;
  assign sq_root[0]  = '0;
  assign sq_pass[0]  = c_pass_q;
  assign sq_ready[RT_W] = m_ready;

  // Cell j settles root bit RT_W-1-j
  for (genvar j = 0; j < RT_W; j++) begin : g_sqrt
    clwa_sqrt_cell #(
      .SQ_W   (SQ_W),
      .RT_W   (RT_W),
      .BIT_POS(RT_W - 1 - j),
      .PASS_W (PASS1_W)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(sq_valid[j]),
      .ready_o(sq_ready[j]),
      .rem_i  (sq_rem[j]),
      .root_i (sq_root[j]),
      .pass_i (sq_pass[j]),
      .valid_o(sq_valid[j+1]),
      .ready_i(sq_ready[j+1]),
      .rem_o  (sq_rem[j+1]),
      .root_o (sq_root[j+1]),
      .pass_o (sq_pass[j+1])
    );
  end

  // ---------------------------------------------------------- stage M
  logic [MW-1:0]      dist_ext;
  logic [RAD_W-1:0]   dist_lo;
  logic               in_lens;
  logic [C-1:0]       m_magx, m_magy;
  logic               m_valid_q;
  logic [NUM_W-1:0]   m_prodx_q, m_prody_q;
  logic [PASS2_W-1:0] m_pass_q;
  logic               dv_ready [0:Q_W];

  // Compare distance with radius and scale offsets by the distance
  always_comb begin
    dist_ext = MW'(sq_root[RT_W]);
    dist_lo  = dist_ext[RAD_W-1:0];
    in_lens  = dist_ext < MW'(radius_q);
    m_magx   = sq_pass[RT_W][2*C+2 +: C];
    m_magy   = sq_pass[RT_W][3*C+2 +: C];
  end

  assign m_ready = !m_valid_q || dv_ready[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (m_ready) begin
      m_valid_q <= sq_valid[RT_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (m_ready && sq_valid[RT_W]) begin
      m_prodx_q <= NUM_W'(m_magx) * NUM_W'(dist_lo);
      m_prody_q <= NUM_W'(m_magy) * NUM_W'(dist_lo);
      m_pass_q  <= {in_lens, sq_pass[RT_W][2*C+1:0]};
    end
  end

  // ---------------------------------------------------------- divide chain
  logic               dv_valid [0:Q_W];
  logic [NUM_W-1:0]   dv_rem_x [0:Q_W];
  logic [NUM_W-1:0]   dv_rem_y [0:Q_W];
  logic [Q_W-1:0]     dv_quo_x [0:Q_W];
  logic [Q_W-1:0]     dv_quo_y [0:Q_W];
  logic [PASS2_W-1:0] dv_pass  [0:Q_W];
  logic               out_ready;

  assign dv_valid[0] = m_valid_q;
  assign dv_rem_x[0] = m_prodx_q;
  assign dv_rem_y[0] = m_prody_q;
  assign dv_quo_x[0] = '0;
  assign dv_quo_y[0] = '0;
  assign dv_pass[0]  = m_pass_q;
  assign dv_ready[Q_W] = out_ready;

  // Cell j settles quotient bit Q_W-1-j
  for (genvar j = 0; j < Q_W; j++) begin : g_div
    clwa_div_cell #(
      .NUM_W  (NUM_W),
      .Q_W    (Q_W),
      .BIT_POS(Q_W - 1 - j),
      .PASS_W (PASS2_W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .radius_i(radius_q),
      .valid_i (dv_valid[j]),
      .ready_o (dv_ready[j]),
      .rem_x_i (dv_rem_x[j]),
      .rem_y_i (dv_rem_y[j]),
      .quo_x_i (dv_quo_x[j]),
      .quo_y_i (dv_quo_y[j]),
      .pass_i  (dv_pass[j]),
      .valid_o (dv_valid[j+1]),
      .ready_i (dv_ready[j+1]),
      .rem_x_o (dv_rem_x[j+1]),
      .rem_y_o (dv_rem_y[j+1]),
      .quo_x_o (dv_quo_x[j+1]),
      .quo_y_o (dv_quo_y[j+1]),
      .pass_o  (dv_pass[j+1])
    );
  end

  // ---------------------------------------------------------- output stage
  logic [C-1:0]     o_px, o_py;
  logic             o_sgnx, o_sgny, o_inside;
  logic [EXT_W-1:0] warp_x, warp_y, own_x, own_y;
  logic [SRC_W-1:0] src_x_d, src_y_d;
  logic             out_valid_q;
  logic [SRC_W-1:0] src_x_q, src_y_q;
  logic             inside_q;

  // Apply the sign and add the center; outside the lens keep the pixel
  always_comb begin
    o_px     = dv_pass[Q_W][C-1:0];
    o_py     = dv_pass[Q_W][2*C-1:C];
    o_sgnx   = dv_pass[Q_W][2*C];
    o_sgny   = dv_pass[Q_W][2*C+1];
    o_inside = dv_pass[Q_W][2*C+2];
    warp_x   = o_sgnx ? (EXT_W'(cx_q) - EXT_W'(dv_quo_x[Q_W]))
                      : (EXT_W'(cx_q) + EXT_W'(dv_quo_x[Q_W]));
    warp_y   = o_sgny ? (EXT_W'(cy_q) - EXT_W'(dv_quo_y[Q_W]))
                      : (EXT_W'(cy_q) + EXT_W'(dv_quo_y[Q_W]));
    own_x    = EXT_W'(o_px);
    own_y    = EXT_W'(o_py);
    src_x_d  = o_inside ? warp_x[SRC_W-1:0] : own_x[SRC_W-1:0];
    src_y_d  = o_inside ? warp_y[SRC_W-1:0] : own_y[SRC_W-1:0];
  end

  assign out_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= dv_valid[Q_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && dv_valid[Q_W]) begin
      src_x_q  <= src_x_d;
      src_y_q  <= src_y_d;
      inside_q <= o_inside;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_W'({src_y_q, src_x_q});
  assign m_axis_tuser  = inside_q;

endmodule

// ----- hw/rtl/clwa_sqrt_cell.sv -----
// One cell of the square root chain: decides a single root bit and hands the
// remainder, partial root and side payload to the next cell.
module clwa_sqrt_cell #(
  parameter int SQ_W    = 25,
  parameter int RT_W    = 13,
  parameter int BIT_POS = 0,
  parameter int PASS_W  = 50
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  logic [SQ_W-1:0]   rem_i,
  input  logic [RT_W-1:0]   root_i,
  input  logic [PASS_W-1:0] pass_i,
  output logic              valid_o,
  input  logic              ready_i,
  output logic [SQ_W-1:0]   rem_o,
  output logic [RT_W-1:0]   root_o,
  output logic [PASS_W-1:0] pass_o
);

  localparam int TW = SQ_W + 2;

  logic              valid_q;
  logic [SQ_W-1:0]   rem_d, rem_q;
  logic [RT_W-1:0]   root_d, root_q;
  logic [PASS_W-1:0] pass_q;
  logic [TW-1:0]     trial;
  logic              take;

  // Try setting this root bit: (root + 2^k)^2 - root^2 = root * 2^(k+1) + 4^k
  always_comb begin
    trial  = (TW'(root_i) << (BIT_POS + 1)) | (TW'(1) << (2 * BIT_POS));
    take   = TW'(rem_i) >= trial;
    rem_d  = take ? (rem_i - trial[SQ_W-1:0]) : rem_i;
    root_d = take ? (root_i | (RT_W'(1) << BIT_POS)) : root_i;
  end

  // Advance whenever the cell is empty or its content moves on
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
      pass_q <= pass_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;
  assign pass_o  = pass_q;

endmodule

// ----- hw/rtl/clwa_div_cell.sv -----
// One cell of the divider chain: decides a single quotient bit for both axes
// and hands remainders, quotients and side payload on. Uses clwa_pkg.
module clwa_div_cell #(
  parameter int NUM_W   = 25,
  parameter int Q_W     = 12,
  parameter int BIT_POS = 0,
  parameter int PASS_W  = 27
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [clwa_pkg::RAD_W-1:0] radius_i,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  logic [NUM_W-1:0]          rem_x_i,
  input  logic [NUM_W-1:0]          rem_y_i,
  input  logic [Q_W-1:0]            quo_x_i,
  input  logic [Q_W-1:0]            quo_y_i,
  input  logic [PASS_W-1:0]         pass_i,
  output logic                      valid_o,
  input  logic                      ready_i,
  output logic [NUM_W-1:0]          rem_x_o,
  output logic [NUM_W-1:0]          rem_y_o,
  output logic [Q_W-1:0]            quo_x_o,
  output logic [Q_W-1:0]            quo_y_o,
  output logic [PASS_W-1:0]         pass_o
);

  logic              valid_q;
  logic [NUM_W-1:0]  trial;
  logic              take_x, take_y;
  logic [NUM_W-1:0]  rem_x_d, rem_x_q, rem_y_d, rem_y_q;
  logic [Q_W-1:0]    quo_x_d, quo_x_q, quo_y_d, quo_y_q;
  logic [PASS_W-1:0] pass_q;

  // Restoring step: subtract the shifted divisor where it fits
  always_comb begin
    trial   = NUM_W'(radius_i) << BIT_POS;
    take_x  = rem_x_i >= trial;
    take_y  = rem_y_i >= trial;
    rem_x_d = take_x ? (rem_x_i - trial) : rem_x_i;
    rem_y_d = take_y ? (rem_y_i - trial) : rem_y_i;
    quo_x_d = take_x ? (quo_x_i | (Q_W'(1) << BIT_POS)) : quo_x_i;
    quo_y_d = take_y ? (quo_y_i | (Q_W'(1) << BIT_POS)) : quo_y_i;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      rem_x_q <= rem_x_d;
      rem_y_q <= rem_y_d;
      quo_x_q <= quo_x_d;
      quo_y_q <= quo_y_d;
      pass_q  <= pass_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_x_o = rem_x_q;
  assign rem_y_o = rem_y_q;
  assign quo_x_o = quo_x_q;
  assign quo_y_o = quo_y_q;
  assign pass_o  = pass_q;

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the convex lens warp address generator.
// Depends on clwa_pkg and convex_lens_warp_address; predicts each source
// coordinate in-bench and checks every result transaction in order.
`timescale 1ns / 100ps

module testbench;

  localparam int COORD_BITS  = 12;
  localparam int SRC_W       = clwa_pkg::SRC_W;
  localparam int CFG_W       = (COORD_BITS > clwa_pkg::RAD_W) ? COORD_BITS : clwa_pkg::RAD_W;
  localparam int PIX_DATA_W  = ((2 * COORD_BITS + 7) / 8) * 8;
  localparam int SRC_DATA_W  = ((2 * SRC_W + 7) / 8) * 8;
  localparam int LATENCY     = 2 * COORD_BITS + 6;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 100;

  // Index past the end of the register map; writes to it must be dropped
  localparam logic [clwa_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [SRC_W-1:0] source_x;
    logic [SRC_W-1:0] source_y;
    logic             inside_lens;
  } warp_result_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [clwa_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]              cfg_data_i;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [PIX_DATA_W-1:0]         s_axis_tdata;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  logic [SRC_DATA_W-1:0]         m_axis_tdata;
  logic                          m_axis_tuser;

  // Lens settings as the bench believes them to be
  logic [COORD_BITS-1:0]     lens_cx;
  logic [COORD_BITS-1:0]     lens_cy;
  logic [clwa_pkg::RAD_W-1:0] lens_radius;

  warp_result_t source_queue[$];
  int           error_count;
  int           cycle_count;
  bit           no_gaps;
  int           sink_left;
  bit           sink_ready;

  convex_lens_warp_address #(
    .COORD_BITS(COORD_BITS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Clock: 2 ns period
  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Floor of the square root, one root bit per step from the top
  function automatic longint unsigned distance_root(input longint unsigned n);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 15; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= n) root = trial;
    end
    return root;
  endfunction

  // Source coordinate for one output pixel under the current lens
  function automatic warp_result_t warp_source(input logic [COORD_BITS-1:0] px,
                                               input logic [COORD_BITS-1:0] py);
    warp_result_t    res;
    longint          dx;
    longint          dy;
    longint          sx;
    longint          sy;
    longint unsigned root_dist;
    dx   = longint'(px) - longint'(lens_cx);
    dy   = longint'(py) - longint'(lens_cy);
    root_dist = distance_root(longint'(dx * dx + dy * dy));
    sx   = longint'(px);
    sy   = longint'(py);
    res.inside_lens = 1'b0;
    if (root_dist < longint'(lens_radius)) begin
      // Signed division truncates toward zero
      sx = (dx * longint'(root_dist)) / longint'(lens_radius) + longint'(lens_cx);
      sy = (dy * longint'(root_dist)) / longint'(lens_radius) + longint'(lens_cy);
      res.inside_lens = 1'b1;
    end
    res.source_x = SRC_W'(sx);
    res.source_y = SRC_W'(sy);
    return res;
  endfunction

  // Idle length: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  // Predict on each accepted pixel, check each accepted result, track writes
  always @(posedge clk_i) begin : check_results
    warp_result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (source_queue.size() == 0) begin
          $error("result transaction with no expectation pending");
          error_count++;
        end else begin
          want = source_queue.pop_front();
          if (m_axis_tdata[SRC_W-1:0] !== want.source_x) begin
            $error("source_x mismatch: expected %0d, got %0d",
                   $signed(want.source_x), $signed(m_axis_tdata[SRC_W-1:0]));
            error_count++;
          end
          if (m_axis_tdata[2*SRC_W-1:SRC_W] !== want.source_y) begin
            $error("source_y mismatch: expected %0d, got %0d",
                   $signed(want.source_y), $signed(m_axis_tdata[2*SRC_W-1:SRC_W]));
            error_count++;
          end
          if (m_axis_tuser !== want.inside_lens) begin
            $error("inside_lens mismatch: expected %0d, got %0d",
                   want.inside_lens, m_axis_tuser);
            error_count++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        source_queue.push_back(warp_source(s_axis_tdata[COORD_BITS-1:0],
                                           s_axis_tdata[2*COORD_BITS-1:COORD_BITS]));
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          clwa_pkg::REG_CENTER_X: lens_cx     = cfg_data_i[COORD_BITS-1:0];
          clwa_pkg::REG_CENTER_Y: lens_cy     = cfg_data_i[COORD_BITS-1:0];
          clwa_pkg::REG_RADIUS:   lens_radius = cfg_data_i[clwa_pkg::RAD_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Result side: alternate ready runs and stalls of random length
  always @(posedge clk_i) begin
    if (sink_left == 0) begin
      if ($urandom_range(99) < 65) begin
        sink_ready = 1'b1;
        sink_left  = $urandom_range(1, 30);
      end else begin
        sink_ready = 1'b0;
        sink_left  = pick_gap();
        if (sink_left == 0) sink_left = 1;
      end
    end else begin
      sink_left--;
    end
    m_axis_tready <= no_gaps ? 1'b1 : sink_ready;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Send one pixel transaction, after a random gap unless no_gaps is set, and hold until accepted
  task automatic send_pixel(input logic [COORD_BITS-1:0] px,
                            input logic [COORD_BITS-1:0] py);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= PIX_DATA_W'({py, px});
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Stop sending and hold until every expected result has come back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (source_queue.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  // Write all lens registers, plus one write to the unused index
  task automatic set_lens(input logic [CFG_W-1:0] cx, input logic [CFG_W-1:0] cy,
                          input logic [CFG_W-1:0] r);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= clwa_pkg::REG_CENTER_X;
    cfg_data_i <= cx;
    @(posedge clk_i);
    cfg_idx_i  <= clwa_pkg::REG_CENTER_Y;
    cfg_data_i <= cy;
    @(posedge clk_i);
    cfg_idx_i  <= clwa_pkg::REG_RADIUS;
    cfg_data_i <= r;
    @(posedge clk_i);
    cfg_idx_i  <= REG_UNUSED;
    cfg_data_i <= CFG_W'($urandom);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
  endtask

  // Radius is zero out of reset: every pixel passes through unchanged
  task automatic test_reset_state();
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd1234, 12'd3000);
    wait_drained();
  endtask

  // Pixels at the center, just inside and exactly on the lens edge, and far outside
  task automatic test_lens_boundary();
    set_lens(13'd2048, 13'd1000, 13'd100);
    send_pixel(12'd2048, 12'd1000);
    send_pixel(12'd2148, 12'd1000);
    send_pixel(12'd2147, 12'd1000);
    send_pixel(12'd2048, 12'd900);
    send_pixel(12'd2048, 12'd901);
    send_pixel(12'd1949, 12'd1000);
    send_pixel(12'd2119, 12'd1071);
    send_pixel(12'd2118, 12'd1070);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    wait_drained();
  endtask

  // Largest radius from opposite corners, oversized center writes, radius one
  task automatic test_extreme_lenses();
    set_lens(13'd0, 13'd0, 13'd8191);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd0);
    wait_drained();
    set_lens(13'h1FFF, 13'h1FFF, 13'd8191);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd0, 12'd4095);
    wait_drained();
    set_lens(13'd4095, 13'd0, 13'd1);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd4094, 12'd0);
    send_pixel(12'd4095, 12'd1);
    wait_drained();
  endtask

  // Random lenses; most pixels land near the center, the rest anywhere
  task automatic test_random_lenses();
    logic [CFG_W-1:0] cx;
    logic [CFG_W-1:0] cy;
    logic [CFG_W-1:0] r;
    int span;
    int x;
    int y;
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      cx = CFG_W'($urandom);
      cy = CFG_W'($urandom);
      case (phase)
        0:       r = '0;
        1:       r = 13'd8191;
        2, 5:    r = CFG_W'($urandom_range(1, 64));
        default: r = CFG_W'($urandom_range(1, 8191));
      endcase
      set_lens(cx, cy, r);
      no_gaps = (phase % 4 == 3);
      span = (r > 4093) ? 4095 : int'(r) + 2;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(99) < 75) begin
          x = int'(cx[COORD_BITS-1:0]) + int'($urandom_range(0, 2 * span)) - span;
          y = int'(cy[COORD_BITS-1:0]) + int'($urandom_range(0, 2 * span)) - span;
          x = (x < 0) ? 0 : (x > 4095) ? 4095 : x;
          y = (y < 0) ? 0 : (y > 4095) ? 4095 : y;
        end else begin
          x = $urandom_range(0, 4095);
          y = $urandom_range(0, 4095);
        end
        send_pixel(COORD_BITS'(x), COORD_BITS'(y));
      end
      wait_drained();
      no_gaps = 1'b0;
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = clwa_pkg::REG_CENTER_X;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    lens_cx       = '0;
    lens_cy       = '0;
    lens_radius   = '0;
    error_count   = 0;
    cycle_count   = 0;
    no_gaps       = 1'b0;
    sink_left     = 0;
    sink_ready    = 1'b1;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_lens_boundary();
    test_extreme_lenses();
    test_random_lenses();

    // Let the pipeline settle, then report
    wait_drained();
    repeat (2 * LATENCY) @(posedge clk_i);
    if (source_queue.size() != 0) begin
      $error("%0d expected results never arrived", source_queue.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
